// ===== rtl/lidar_scan_destagger_unit_defines.svh =====
// ----------------------------------------------------------------------------
// lidar scan destagger assertion macros
// shared concurrent assertion forms; define NO_ASSERTIONS to drop them all
// ----------------------------------------------------------------------------
`ifndef LIDAR_SCAN_DESTAGGER_UNIT_DEFINES_SVH
`define LIDAR_SCAN_DESTAGGER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define LSD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("lsd assertion failed");
// next-cycle implication
`define LSD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("lsd assertion failed");
`else
`define LSD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LSD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/lsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_pkg
// shared sizes, codes and types of the lidar scan destagger
// ----------------------------------------------------------------------------
package lsd_pkg;

	localparam int unsigned MAX_ROWS    = 128;
	localparam int unsigned MAX_COLUMNS = 2048;

	// table address, row counter (holds MAX_ROWS), column field and width value
	localparam int unsigned ROW_AW = $clog2(MAX_ROWS);
	localparam int unsigned ROW_CW = $clog2(MAX_ROWS + 1);
	localparam int unsigned COL_W  = $clog2(MAX_COLUMNS);
	localparam int unsigned COL_CW = $clog2(MAX_COLUMNS + 1);

	// register widths
	localparam int unsigned ROWS_REG_W = 8;
	localparam int unsigned COLS_REG_W = 12;
	localparam int unsigned CFG_W      = 12;
	localparam int unsigned CFG_IDX_W  = 2;

	// item field widths
	localparam int unsigned TROW_W  = 7;
	localparam int unsigned SHIFT_W = 11;
	localparam int unsigned REFL_W  = 16;
	localparam int unsigned FRAC_W  = 16;
	localparam int unsigned STAMP_W = 32;
	localparam int unsigned PROW_W  = 7;
	localparam int unsigned PCOL_W  = 11;
	localparam int unsigned PVAL_W  = 8;

	localparam int unsigned IN_FIELDS_W  = TROW_W + SHIFT_W + 1 + REFL_W + FRAC_W + STAMP_W;
	localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int unsigned OUT_FIELDS_W = PROW_W + PCOL_W + PVAL_W + REFL_W + 2 * STAMP_W;
	localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	// scan period of 0.1 s in ns spread over the columns
	localparam int unsigned TIME_SCALE = 100000000;
	localparam int unsigned QUO_W      = $clog2(TIME_SCALE);
	localparam int unsigned DIVIDEND_W = COL_W + QUO_W;
	localparam int unsigned DCNT_W     = $clog2(QUO_W);

	// reciprocal of 255 for 16-bit values: (x * 0x8081) >> 23 is exact
	localparam int unsigned RECIP255     = 32'h8081;
	localparam int unsigned RECIP255_SH  = 23;
	localparam int unsigned INTENS_SCALE = 255;
	localparam int unsigned INTENS_SH    = 15;

	localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd2;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_POINT = 1'b1;

	typedef enum logic [1:0] {
		MODE_PASS   = 2'd0,
		MODE_TIME   = 2'd1,
		MODE_SCALE  = 2'd2,
		MODE_INTENS = 2'd3
	} mode_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== rtl/lsd_shift_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_shift_ram
// per-row column shift memory, one write and one registered read port
// ----------------------------------------------------------------------------
module lsd_shift_ram (
	input  logic                         clk,
	input  logic                         we,
	input  logic [lsd_pkg::ROW_AW-1:0]  waddr,
	input  logic [lsd_pkg::SHIFT_W-1:0] wdata,
	input  logic                         re,
	input  logic [lsd_pkg::ROW_AW-1:0]  raddr,
	output logic [lsd_pkg::SHIFT_W-1:0] rdata
);
	import lsd_pkg::*;

	logic [SHIFT_W-1:0] mem [MAX_ROWS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/lsd_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_div
// recomputed point time: u * 1e8 / columns, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lsd_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lsd_pkg::COL_W-1:0]  u,
	input  logic [lsd_pkg::COL_CW-1:0] divisor,
	output lsd_pkg::div_stat_t          stat,
	output logic [lsd_pkg::QUO_W-1:0]  quotient
);
	import lsd_pkg::*;

	logic              load_q;
	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [COL_W-1:0]  u_q;
	logic [COL_CW-1:0] d_q;
	logic [COL_CW-1:0] rem_q;
	logic [QUO_W-1:0]  quo_q;

	logic [DIVIDEND_W-1:0] prod;
	logic [COL_CW:0]       trial;
	logic                  fits;

	assign prod  = DIVIDEND_W'(u_q) * DIVIDEND_W'(TIME_SCALE);
	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= 1'b0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			priority if (start) begin
				load_q <= 1'b1;
				busy_q <= 1'b1;
				done_q <= 1'b0;
			end else if (load_q) begin
				load_q <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	// top bits of the product stay below the divisor since u < columns
	always_ff @(posedge clk) begin
		if (start) begin
			u_q <= u;
			d_q <= divisor;
		end
		if (load_q) begin
			rem_q <= COL_CW'(prod[DIVIDEND_W-1:QUO_W]);
			quo_q <= prod[QUO_W-1:0];
		end else if (busy_q) begin
			rem_q <= fits ? COL_CW'(trial - {1'b0, d_q}) : trial[COL_CW-1:0];
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

// ===== rtl/lidar_scan_destagger_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_scan_destagger_unit
// places raw-order lidar points on a destaggered image and treats their values
// ----------------------------------------------------------------------------
// A shift-table load is written as it is accepted. A point passes accept, shift
// memory read and finish in modes 0, 2 and 3; in mode 1 the time recompute
// runs between them through a bit-serial divider of a product step, 27
// quotient steps and a hand-over of the quotient; a surplus point skips the
// divider in every mode. The result sits in an output register, so the next
// item is taken while it waits; a point only stalls in its finish cycle while
// that register is still full. The shift memory needs no clearing after reset:
// rows must be loaded before points use them.
`include "lidar_scan_destagger_unit_defines.svh"

module lidar_scan_destagger_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lsd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lsd_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// table_row, shift_value, first_of_frame, raw_reflectivity,
	// intensity_fraction, point_stamp
	input  logic [lsd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// operation
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// pixel_row, pixel_column, pixel_value, new_reflectivity, new_stamp,
	// frame_maximum
	output logic [lsd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// frame_done
	output logic                              m_axis_tlast,
	// frame_error
	output logic                              m_axis_tuser
);
	import lsd_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CALC = 4'b0010,
		S_DIV  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	// input fields
	logic [TROW_W-1:0]  in_trow;
	logic [SHIFT_W-1:0] in_shift;
	logic               in_first;
	logic [REFL_W-1:0]  in_refl;
	logic [FRAC_W-1:0]  in_frac;
	logic [STAMP_W-1:0] in_stamp;

	assign in_trow  = s_axis_tdata[TROW_W-1:0];
	assign in_shift = s_axis_tdata[TROW_W +: SHIFT_W];
	assign in_first = s_axis_tdata[TROW_W + SHIFT_W];
	assign in_refl  = s_axis_tdata[TROW_W + SHIFT_W + 1 +: REFL_W];
	assign in_frac  = s_axis_tdata[TROW_W + SHIFT_W + 1 + REFL_W +: FRAC_W];
	assign in_stamp = s_axis_tdata[TROW_W + SHIFT_W + 1 + REFL_W + FRAC_W +: STAMP_W];

	// configuration
	logic [ROWS_REG_W-1:0] rows_q;
	logic [COLS_REG_W-1:0] cols_q;
	mode_t                 mode_q;
	logic [ROW_CW-1:0]     rows_used;
	logic [COL_CW-1:0]     cols_used;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_REG_W'(128);
			cols_q <= COLS_REG_W'(1024);
			mode_q <= MODE_PASS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROWS:    rows_q <= cfg_wdata[ROWS_REG_W-1:0];
				CFG_COLUMNS: cols_q <= cfg_wdata[COLS_REG_W-1:0];
				CFG_MODE:    mode_q <= mode_t'(cfg_wdata[1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		if (rows_q == '0) begin
			rows_used = ROW_CW'(1);
		end else if (32'(rows_q) > MAX_ROWS) begin
			rows_used = ROW_CW'(MAX_ROWS);
		end else begin
			rows_used = ROW_CW'(rows_q);
		end
		if (cols_q == '0) begin
			cols_used = COL_CW'(1);
		end else if (32'(cols_q) > MAX_COLUMNS) begin
			cols_used = COL_CW'(MAX_COLUMNS);
		end else begin
			cols_used = COL_CW'(cols_q);
		end
	end

	// control and frame state
	state_t             state_q;
	logic [ROW_CW-1:0]  row_q;
	logic [COL_W-1:0]   col_q;
	logic [STAMP_W-1:0] max_q;
	logic               ovf_q;
	logic               out_valid_q;

	// point payload
	logic [REFL_W-1:0]  refl_in_q;
	logic [FRAC_W-1:0]  frac_q;
	logic [STAMP_W-1:0] stamp_in_q;
	logic [COL_W-1:0]   u_q;
	logic [REFL_W-1:0]  refl_q;
	logic               surplus_q;

	// output register
	logic [PROW_W-1:0]  out_row_q;
	logic [PCOL_W-1:0]  out_col_q;
	logic [REFL_W-1:0]  out_refl_q;
	logic [STAMP_W-1:0] out_stamp_q;
	logic [STAMP_W-1:0] out_max_q;
	logic               out_done_q;
	logic               out_err_q;

	logic accept;
	logic is_load;
	logic is_point;

	assign s_axis_tready = state_q == S_IDLE;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_load       = accept && (s_axis_tuser == OP_LOAD);
	assign is_point      = accept && (s_axis_tuser == OP_POINT);

	// shift memory
	logic [SHIFT_W-1:0] rd_shift;
	logic [SHIFT_W-1:0] wr_shift;
	logic               wr_en;
	logic [ROW_AW-1:0]  rd_addr;

	// a shift at or past the width is kept as zero
	assign wr_shift = (COL_CW'(in_shift) < cols_used) ? in_shift : '0;
	assign wr_en    = is_load && (32'(in_trow) < MAX_ROWS);
	assign rd_addr  = in_first ? '0 : row_q[ROW_AW-1:0];

	lsd_shift_ram u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (in_trow[ROW_AW-1:0]),
		.wdata (wr_shift),
		.re    (is_point),
		.raddr (rd_addr),
		.rdata (rd_shift)
	);

	// position and reflectivity, in the cycle after the memory read
	logic [COL_CW-1:0]         s_eff;
	logic [COL_CW-1:0]         col_sum;
	logic [COL_CW-1:0]         u_calc;
	logic                      surplus;
	logic [REFL_W*2-1:0]       scale_prod;
	logic [FRAC_W+8-1:0]       intens_prod;
	logic [REFL_W-1:0]         refl_calc;
	logic                      need_div;

	assign s_eff   = (COL_CW'(rd_shift) >= cols_used) ? '0 : COL_CW'(rd_shift);
	assign col_sum = COL_CW'(col_q) + s_eff;
	assign u_calc  = (col_sum >= cols_used) ? col_sum - cols_used : col_sum;
	assign surplus = ovf_q || (row_q >= rows_used) || (COL_CW'(col_q) >= cols_used);
	assign need_div = (mode_q == MODE_TIME) && !surplus;

	assign scale_prod  = (REFL_W*2)'(refl_in_q) * (REFL_W*2)'(RECIP255);
	assign intens_prod = (FRAC_W+8)'(frac_q) * (FRAC_W+8)'(INTENS_SCALE);

	always_comb begin
		unique case (mode_q)
			MODE_SCALE:  refl_calc = REFL_W'(scale_prod >> RECIP255_SH);
			MODE_INTENS: refl_calc = REFL_W'(intens_prod >> INTENS_SH);
			default:     refl_calc = refl_in_q;
		endcase
	end

	// time recompute
	div_stat_t         div_stat;
	logic [QUO_W-1:0]  quotient;
	logic              div_start;

	assign div_start = (state_q == S_CALC) && need_div;

	lsd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.u        (u_calc[COL_W-1:0]),
		.divisor  (cols_used),
		.stat     (div_stat),
		.quotient (quotient)
	);

	// finish
	logic               fin_go;
	logic [STAMP_W-1:0] stamp_new;
	logic [STAMP_W-1:0] max_new;
	logic               fin_done;
	logic               col_wrap;

	assign fin_go    = (state_q == S_FIN) && (!out_valid_q || m_axis_tready);
	assign stamp_new = (mode_q == MODE_TIME) ? STAMP_W'(quotient) : stamp_in_q;
	assign max_new   = (stamp_new > max_q) ? stamp_new : max_q;
	assign fin_done  = (row_q == rows_used - 1'b1) &&
		(COL_CW'(col_q) == cols_used - 1'b1);
	assign col_wrap  = (COL_CW'(col_q) + 1'b1) >= cols_used;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			max_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (is_point) begin
						state_q <= S_CALC;
						if (in_first) begin
							row_q <= '0;
							col_q <= '0;
							max_q <= '0;
							ovf_q <= 1'b0;
						end
					end
				end
				S_CALC: begin
					state_q <= need_div ? S_DIV : S_FIN;
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
						if (surplus_q) begin
							ovf_q <= 1'b1;
						end else begin
							max_q <= max_new;
							if (col_wrap) begin
								col_q <= '0;
								row_q <= row_q + 1'b1;
							end else begin
								col_q <= col_q + 1'b1;
							end
							if (fin_done) begin
								ovf_q <= 1'b1;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (is_point) begin
			refl_in_q  <= in_refl;
			frac_q     <= in_frac;
			stamp_in_q <= in_stamp;
		end
		if (state_q == S_CALC) begin
			u_q       <= u_calc[COL_W-1:0];
			refl_q    <= refl_calc;
			surplus_q <= surplus;
		end
		if (fin_go) begin
			out_max_q <= surplus_q ? max_q : max_new;
			out_err_q <= surplus_q;
			if (surplus_q) begin
				out_row_q   <= '0;
				out_col_q   <= '0;
				out_refl_q  <= '0;
				out_stamp_q <= '0;
				out_done_q  <= 1'b0;
			end else begin
				out_row_q   <= row_q[PROW_W-1:0];
				out_col_q   <= PCOL_W'(u_q);
				out_refl_q  <= refl_q;
				out_stamp_q <= stamp_new;
				out_done_q  <= fin_done;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'({out_max_q, out_stamp_q, out_refl_q,
		out_refl_q[PVAL_W-1:0], out_col_q, out_row_q});
	assign m_axis_tlast  = out_done_q;
	assign m_axis_tuser  = out_err_q;

	`LSD_ASSERT_IMP(a_err_not_done, clk, arst_n, m_axis_tvalid, !(m_axis_tlast && m_axis_tuser))
	`LSD_ASSERT_IMP(a_err_no_pos, clk, arst_n, m_axis_tvalid && m_axis_tuser, (out_row_q == '0) && (out_col_q == '0))
	`LSD_ASSERT_IMP(a_col_in_width, clk, arst_n, m_axis_tvalid && !m_axis_tuser, COL_CW'(out_col_q) < cols_used)
	`LSD_ASSERT_NXT(a_done_closes, clk, arst_n, fin_go && !surplus_q && fin_done, ovf_q)
	`LSD_ASSERT_IMP(a_div_in_state, clk, arst_n, div_stat.busy || div_stat.done, state_q == S_DIV)

endmodule
